// ===== rtl/sts_pkg.sv =====
package sts_pkg;

  // payload widths
  localparam int ValueW  = 14;
  localparam int StatusW = 2;

  // table size and match reduction grouping
  localparam int DefaultDepth = 256;
  localparam int GroupSize    = 64;

  // operation codes
  localparam logic OpLoad   = 1'b0;
  localparam logic OpSearch = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] StLoadOk   = 2'd0;
  localparam logic [StatusW-1:0] StLoadFull = 2'd1;
  localparam logic [StatusW-1:0] StFound    = 2'd2;
  localparam logic [StatusW-1:0] StAbsent   = 2'd3;

  // what one cell hands to the cell above it
  typedef struct packed {
    logic              gt;
    logic              valid;
    logic [ValueW-1:0] entry;
  } sts_link_t;

endpackage

// ===== rtl/sorted_table_binary_search.sv =====
// sequence: an accepted word passes through insert or compare, group or, final or and
// the status register before its status strobe comes out
// a new word is taken only once the last one is through; busy is high while it is in flight
// the receiver cannot stall, so the status strobe is never held off
// reset (async, active low) empties the table at once through the cell valid bits
module sorted_table_binary_search #(
  parameter int DEPTH = sts_pkg::DefaultDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic [sts_pkg::ValueW-1:0]  item_value_i,
  output logic                        done_o,
  output logic [sts_pkg::StatusW-1:0] status_o
);
  import sts_pkg::*;

  localparam int CountW = $clog2(DEPTH + 1);

  // one-hot sequencer
  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCell  = 4'b0010,
    StGroup = 4'b0100,
    StFinal = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic                 op_q;
  logic [ValueW-1:0]    value_q;
  logic [CountW-1:0]    count_q, count_d;
  logic                 full_q, full_d;
  logic                 done_q, done_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic                 accept;
  logic                 table_full;
  logic                 ins_en;
  logic                 found;

  // cell chain signals
  sts_link_t            link [DEPTH];
  sts_link_t            left [DEPTH];
  logic [DEPTH-1:0]     match;

  assign accept     = start && !busy;
  assign table_full = (count_q == CountW'(DEPTH));
  // on an insert, the whole chain above the insert point shifts at once
  assign ins_en     = (state_q == StCell) && (op_q == OpLoad) && !table_full;

  // cell zero sees nothing below it
  assign left[0] = '{gt: 1'b0, valid: 1'b0, entry: '0};

  for (genvar i = 1; i < DEPTH; i++) begin : g_link
    assign left[i] = link[i-1];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sts_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ins_en_i (ins_en),
      .key_i    (value_q),
      .left_i   (left[i]),
      .link_o   (link[i]),
      .match_o  (match[i])
    );
  end

  // match bits registered in the cells, then or-reduced in a registered group level and a final or
  sts_match_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .match_i (match),
    .any_o   (found)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    full_d   = full_q;
    done_d   = 1'b0;
    status_d = status_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StCell;
        end
      end
      StCell: begin
        // load decision taken against the count before this word
        full_d = table_full;
        if (ins_en) begin
          count_d = count_q + CountW'(1);
        end
        state_d = StGroup;
      end
      StGroup: begin
        state_d = StFinal;
      end
      StFinal: begin
        done_d = 1'b1;
        if (op_q == OpLoad) begin
          status_d = full_q ? StLoadFull : StLoadOk;
        end else begin
          status_d = found ? StFound : StAbsent;
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      full_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      full_q  <= full_d;
      done_q  <= done_d;
    end
  end

  // word and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      value_q <= item_value_i;
    end
    status_q <= status_d;
  end

  assign busy     = (state_q != StIdle);
  assign done_o   = done_q;
  assign status_o = status_q;

  // the strobe only ever follows the final step
  a_done_after_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StFinal))
    else $error("status strobe without a finished word");

  // an accepted word always occupies the block on the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && state_q == StCell))
    else $error("accepted word did not start");

  // the table never holds more than its depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(DEPTH))
    else $error("entry count beyond depth");

  // the count moves only on a load into a table with room
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(ins_en) && count_q == $past(count_q) + CountW'(1)))
    else $error("entry count changed outside an insert");

endmodule

// ===== rtl/sts_cell.sv =====
module sts_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ins_en_i,
  input  logic [sts_pkg::ValueW-1:0] key_i,
  input  sts_pkg::sts_link_t        left_i,
  output sts_pkg::sts_link_t        link_o,
  output logic                      match_o
);
  import sts_pkg::*;

  logic [ValueW-1:0] entry_q, entry_d;
  logic              valid_q, valid_d;
  logic              match_q;
  logic              gt;

  // an empty cell counts as greater, so the new word lands at the end
  assign gt = !valid_q || (entry_q > key_i);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ins_en_i) begin
      if (left_i.gt) begin
        entry_d = left_i.entry;
        valid_d = left_i.valid;
      end else if (gt) begin
        entry_d = key_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= valid_q && (entry_q == key_i);
    end
  end

  assign link_o.gt    = gt;
  assign link_o.valid = valid_q;
  assign link_o.entry = entry_q;
  assign match_o      = match_q;

endmodule

// ===== rtl/sts_match_tree.sv =====
module sts_match_tree #(
  parameter int DEPTH = sts_pkg::DefaultDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DEPTH-1:0] match_i,
  output logic             any_o
);
  import sts_pkg::*;

  localparam int NumGroups = (DEPTH + GroupSize - 1) / GroupSize;

  logic [NumGroups-1:0] group_d, group_q;

  // first level: or of each group of cells, registered
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      group_d[g] = 1'b0;
      for (int c = 0; c < GroupSize; c++) begin
        if (g * GroupSize + c < DEPTH) begin
          group_d[g] = group_d[g] | match_i[g * GroupSize + c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
    end else begin
      group_q <= group_d;
    end
  end

  assign any_o = |group_q;

endmodule

// ===== dv/tb_sorted_table_binary_search.sv =====
module tb_sorted_table_binary_search;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam int Depth       = DefaultDepth;
  localparam int RandomWords = 2000;
  // idling is not switched on once this many random words remain
  localparam int QuietTail   = 300;
  localparam int CycleLimit  = 400000;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 16;

  localparam logic [ValueW-1:0] ValueMax = '1;
  // a pair of neighboring keys around an arbitrary mid-range value
  localparam logic [ValueW-1:0] MidKey   = 14'd10000;
  localparam logic [ValueW-1:0] MidBelow = 14'd9999;

  // keeps its own sorted copy of the table and the status each word must give
  class table_status_board;
    logic [ValueW-1:0]  entries[$];
    logic [StatusW-1:0] status_due[$];
    int unsigned        errors;

    // updates the table copy for a load and returns the status the block owes
    function logic [StatusW-1:0] predict_status(logic op, logic [ValueW-1:0] value);
      int pos;
      int lo;
      int hi;
      int mid;
      if (op == OpLoad) begin
        if (entries.size() >= Depth) return StLoadFull;
        // equal values go after the copies already held
        pos = 0;
        while (pos < entries.size() && entries[pos] <= value) pos++;
        entries.insert(pos, value);
        return StLoadOk;
      end
      lo = 0;
      hi = entries.size();
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (entries[mid] == value) return StFound;
        if (entries[mid] < value) lo = mid + 1;
        else hi = mid;
      end
      return StAbsent;
    endfunction

    function void note_word(logic op, logic [ValueW-1:0] value);
      status_due.push_back(predict_status(op, value));
    endfunction

    function void check_status(logic [StatusW-1:0] got);
      logic [StatusW-1:0] want;
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) $display("status %0d strobed with no word pending", got);
        return;
      end
      want = status_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= ReportLimit) $display("status mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              operation_i;
  logic [ValueW-1:0] item_value_i;
  logic              done_o;
  logic [StatusW-1:0] status_o;

  table_status_board board;
  int unsigned       cycle_count = 0;

  sorted_table_binary_search #(
    .DEPTH(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .item_value_i(item_value_i),
    .done_o      (done_o),
    .status_o    (status_o)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs or drops a status
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // the receiver never stalls: every strobe is one status word
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_status(status_o);
  end

  // presents one word at the falling edge and holds it until the block takes it;
  // start stays high on return so back-to-back words need no extra edge
  task automatic send_word(logic op, logic [ValueW-1:0] value);
    @(negedge clk_i);
    start        <= 1'b1;
    operation_i  <= op;
    item_value_i <= value;
    do @(posedge clk_i); while (busy);
    board.note_word(op, value);
  endtask

  // holds start low, with junk on the payload to show it is ignored
  task automatic pause(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start        <= 1'b0;
      operation_i  <= 1'($urandom);
      item_value_i <= ValueW'($urandom);
    end
  endtask

  // picks a value biased toward the interesting spots of the current table:
  // held entries, their neighbors, the range ends and a small set of repeats
  function automatic logic [ValueW-1:0] pick_value(logic op);
    int unsigned       roll;
    int                held;
    logic [ValueW-1:0] near;
    roll = $urandom_range(99);
    held = board.entries.size();
    if (held != 0) near = board.entries[$urandom_range(held - 1)];
    if (op == OpSearch) begin
      if (held != 0 && roll < 45) return near;
      if (held != 0 && roll < 65) return $urandom_range(1) ? near + 1'b1 : near - 1'b1;
      if (roll < 75) return $urandom_range(1) ? ValueMax : '0;
      return ValueW'($urandom);
    end
    // loads: duplicates from a small pool, plus neighbors and extremes
    if (roll < 20) return ValueW'($urandom_range(7)) * 14'd2047;
    if (held != 0 && roll < 30) return near;
    if (held != 0 && roll < 40) return $urandom_range(1) ? near + 1'b1 : near - 1'b1;
    if (roll < 45) return $urandom_range(1) ? ValueMax : '0;
    return ValueW'($urandom);
  endfunction

  initial begin
    logic op;
    bit   idle_on;

    board        = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = OpLoad;
    item_value_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table: nothing can be found
    send_word(OpSearch, '0);
    send_word(OpSearch, ValueMax);
    pause(3);
    // range ends, a lone high bit, and duplicates of the low end and of the high bit
    send_word(OpLoad, ValueMax);
    send_word(OpLoad, '0);
    send_word(OpLoad, 14'h2000);
    send_word(OpLoad, 14'h2000);
    send_word(OpLoad, '0);
    pause(1);
    send_word(OpSearch, '0);
    send_word(OpSearch, ValueMax);
    send_word(OpSearch, 14'h2000);
    send_word(OpSearch, 14'h1fff);
    send_word(OpSearch, 14'h2001);
    send_word(OpSearch, 14'd1);
    send_word(OpSearch, ValueMax - 1'b1);
    // alternating bit patterns and a close pair of keys
    send_word(OpLoad, 14'h1555);
    send_word(OpLoad, 14'h2aaa);
    send_word(OpLoad, MidKey);
    send_word(OpLoad, MidBelow);
    pause(2);
    send_word(OpSearch, 14'h1555);
    send_word(OpSearch, 14'h2aaa);
    send_word(OpSearch, MidKey);
    send_word(OpSearch, MidBelow);
    send_word(OpSearch, MidKey + 1'b1);

    // random mix; at this load share the table fills well before the end,
    // so the late words probe a full table and exercise dropped loads
    idle_on = 1'b0;
    for (int i = 0; i < RandomWords; i++) begin
      if (i % 64 == 0) idle_on = ($urandom_range(2) != 0) && (i < RandomWords - QuietTail);
      op = ($urandom_range(99) < 35) ? OpLoad : OpSearch;
      send_word(op, pick_value(op));
      if (idle_on && $urandom_range(3) == 0) pause($urandom_range(1, 16));
    end

    @(negedge clk_i);
    start <= 1'b0;

    // wait for every status, then drain for anything stray
    while (board.status_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.errors == 0 && board.status_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
